/* rtl/calendar_date_time_stepper_core_assert.svh */
// Assertion macros shared by the calendar stepper RTL.
// Each macro takes a label, the clock, the reset, the property terms and a message.
`ifndef CALENDAR_DATE_TIME_STEPPER_CORE_ASSERT_SVH
`define CALENDAR_DATE_TIME_STEPPER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDTS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/cdts_pkg.sv */
`default_nettype none

package cdts_pkg;

   localparam int FUNC_W   = 4;
   localparam int LOAD_W   = 14;
   localparam int MINUTE_W = 6;
   localparam int HOUR_W   = 5;
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;

   // Operation codes carried in the func field.
   localparam logic [FUNC_W-1:0] FUNC_MINUTE_UP   = 4'd0;
   localparam logic [FUNC_W-1:0] FUNC_MINUTE_DOWN = 4'd1;
   localparam logic [FUNC_W-1:0] FUNC_HOUR_UP     = 4'd2;
   localparam logic [FUNC_W-1:0] FUNC_HOUR_DOWN   = 4'd3;
   localparam logic [FUNC_W-1:0] FUNC_DAY_UP      = 4'd4;
   localparam logic [FUNC_W-1:0] FUNC_DAY_DOWN    = 4'd5;
   localparam logic [FUNC_W-1:0] FUNC_MONTH_UP    = 4'd6;
   localparam logic [FUNC_W-1:0] FUNC_MONTH_DOWN  = 4'd7;
   localparam logic [FUNC_W-1:0] FUNC_YEAR_UP     = 4'd8;
   localparam logic [FUNC_W-1:0] FUNC_YEAR_DOWN   = 4'd9;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_MINUTE = 4'd10;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_HOUR   = 4'd11;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_DAY    = 4'd12;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_MONTH  = 4'd13;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_YEAR   = 4'd14;

   localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
   localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
   localparam logic [DAY_W-1:0]    DAY_MAX    = 5'd31;
   localparam logic [MONTH_W-1:0]  MONTH_MAX  = 4'd12;
   localparam logic [YEAR_W-1:0]   YEAR_MAX   = 14'd9999;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
   } cdts_time_type;

   // Days in a month. Month zero counts as a long month.
   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         4'd2:                       len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
         default:                    len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

/* rtl/cdts_req_if.sv */
`default_nettype none

interface cdts_req_if;
   import cdts_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [LOAD_W-1:0]   load_value;

   modport source (output valid, func, load_value, input ready);
   modport sink   (input valid, func, load_value, output ready);
endinterface

`default_nettype wire

/* rtl/cdts_rsp_if.sv */
`default_nettype none

interface cdts_rsp_if;
   import cdts_pkg::*;

   logic                valid;
   logic                ready;
   logic [MINUTE_W-1:0] minute_out;
   logic [HOUR_W-1:0]   hour_out;
   logic [DAY_W-1:0]    day_out;
   logic [MONTH_W-1:0]  month_out;
   logic [YEAR_W-1:0]   year_out;
   logic                load_rejected;

   modport source (output valid, minute_out, hour_out, day_out, month_out, year_out,
                   load_rejected, input ready);
   modport sink   (input valid, minute_out, hour_out, day_out, month_out, year_out,
                   load_rejected, output ready);
endinterface

`default_nettype wire

/* rtl/cdts_step.sv */
`default_nettype none

// Next-state logic: one step with its carry or borrow chain, or one load.
module cdts_step (
   input  cdts_pkg::cdts_time_type         cur,
   input  logic [cdts_pkg::FUNC_W-1:0]     func,
   input  logic [cdts_pkg::LOAD_W-1:0]     load_value,
   output cdts_pkg::cdts_time_type         nxt,
   output logic                            rejected
);
   import cdts_pkg::*;

   logic                 min_up, min_dn, hr_up, hr_dn, day_up, day_dn;
   logic                 mon_up, mon_dn, yr_up, yr_dn;
   logic [DAY_W-1:0]     len_cur, len_new;
   logic [MONTH_W-1:0]   month_new;
   logic [YEAR_W-1:0]    year_new;

   // Carry chain upward and borrow chain downward.
   assign min_up = (func == FUNC_MINUTE_UP);
   assign min_dn = (func == FUNC_MINUTE_DOWN);
   assign hr_up  = (func == FUNC_HOUR_UP)    || (min_up && cur.minute >= MINUTE_MAX);
   assign hr_dn  = (func == FUNC_HOUR_DOWN)  || (min_dn && cur.minute == '0);
   assign day_up = (func == FUNC_DAY_UP)     || (hr_up && cur.hour >= HOUR_MAX);
   assign day_dn = (func == FUNC_DAY_DOWN)   || (hr_dn && cur.hour == '0);
   assign len_cur = month_length(cur.month, cur.year[1:0] == 2'b00);
   assign mon_up = (func == FUNC_MONTH_UP)   || (day_up && cur.day >= len_cur);
   assign mon_dn = (func == FUNC_MONTH_DOWN) || (day_dn && cur.day <= 5'd1);
   assign yr_up  = (func == FUNC_YEAR_UP)    || (mon_up && cur.month >= MONTH_MAX);
   assign yr_dn  = (func == FUNC_YEAR_DOWN)  || (mon_dn && cur.month <= 4'd1);

   always_comb begin
      if (mon_up) begin
         month_new = (cur.month >= MONTH_MAX) ? 4'd1 : cur.month + 4'd1;
      end else if (mon_dn) begin
         month_new = (cur.month <= 4'd1) ? MONTH_MAX : cur.month - 4'd1;
      end else begin
         month_new = cur.month;
      end

      if (yr_up) begin
         year_new = (cur.year < YEAR_MAX) ? cur.year + 14'd1 : YEAR_MAX;
      end else if (yr_dn) begin
         year_new = (cur.year > '0) ? cur.year - 14'd1 : '0;
      end else begin
         year_new = cur.year;
      end
   end

   // A day borrow lands on the last day of the month it borrowed into.
   assign len_new = month_length(month_new, year_new[1:0] == 2'b00);

   always_comb begin
      nxt      = cur;
      rejected = 1'b0;

      if (min_up) begin
         nxt.minute = (cur.minute >= MINUTE_MAX) ? '0 : cur.minute + 6'd1;
      end else if (min_dn) begin
         nxt.minute = (cur.minute == '0) ? MINUTE_MAX : cur.minute - 6'd1;
      end

      if (hr_up) begin
         nxt.hour = (cur.hour >= HOUR_MAX) ? '0 : cur.hour + 5'd1;
      end else if (hr_dn) begin
         nxt.hour = (cur.hour == '0) ? HOUR_MAX : cur.hour - 5'd1;
      end

      if (day_up) begin
         nxt.day = (cur.day >= len_cur) ? 5'd1 : cur.day + 5'd1;
      end else if (day_dn) begin
         nxt.day = (cur.day <= 5'd1) ? len_new : cur.day - 5'd1;
      end

      nxt.month = month_new;
      nxt.year  = year_new;

      case (func)
         FUNC_LOAD_MINUTE: begin
            if (load_value <= 14'(MINUTE_MAX)) nxt.minute = load_value[MINUTE_W-1:0];
            else rejected = 1'b1;
         end
         FUNC_LOAD_HOUR: begin
            if (load_value <= 14'(HOUR_MAX)) nxt.hour = load_value[HOUR_W-1:0];
            else rejected = 1'b1;
         end
         FUNC_LOAD_DAY: begin
            if (load_value >= 14'd1 && load_value <= 14'(DAY_MAX))
               nxt.day = load_value[DAY_W-1:0];
            else rejected = 1'b1;
         end
         FUNC_LOAD_MONTH: begin
            if (load_value >= 14'd1 && load_value <= 14'(MONTH_MAX))
               nxt.month = load_value[MONTH_W-1:0];
            else rejected = 1'b1;
         end
         FUNC_LOAD_YEAR: begin
            if (load_value >= 14'd1 && load_value <= YEAR_MAX) nxt.year = load_value;
            else rejected = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/calendar_date_time_stepper_core.sv */
// Channel    Dir  Carries
// req_chan   in   func, load_value: one step or load request per transaction
// rsp_chan   out  minute/hour/day/month/year after the operation, load_rejected
//
// Every request transaction produces exactly one response transaction, in the next cycle.
// Throughput is one transaction per cycle while the response is not stalled; the limit is the
// combinational carry and borrow chain from the time registers through cdts_step back into them.
// Reset (synchronous, active high) clears the time to all zeros and empties the response.
// A stalled response holds its register; requests keep flowing while the response
// register drains in the same cycle, so req_chan.ready drops only under a stalled response.
`default_nettype none

`include "calendar_date_time_stepper_core_assert.svh"

module calendar_date_time_stepper_core (
   input  logic        clock,
   input  logic        reset,
   cdts_req_if.sink    req_chan,
   cdts_rsp_if.source  rsp_chan
);
   import cdts_pkg::*;

   cdts_time_type  time_ff, time_in;
   cdts_time_type  rsp_time_ff;
   logic           rsp_rejected_ff, rsp_rejected_in;
   logic           rsp_valid_ff;
   logic           req_fire;
   logic           rsp_fields_ok;
   logic           step_fire;

   // The response register can take a new result when it is empty or being emptied.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // All of the work for one transaction happens here, between the time registers
   // and the response register.
   cdts_step u_step (
      .cur        (time_ff),
      .func       (req_chan.func),
      .load_value (req_chan.load_value),
      .nxt        (time_in),
      .rejected   (rsp_rejected_in)
   );

   // Control state and the time registers, which must reset to zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            time_ff      <= time_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload; only meaningful while the response is valid.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_time_ff     <= time_in;
         rsp_rejected_ff <= rsp_rejected_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.minute_out    = rsp_time_ff.minute;
   assign rsp_chan.hour_out      = rsp_time_ff.hour;
   assign rsp_chan.day_out       = rsp_time_ff.day;
   assign rsp_chan.month_out     = rsp_time_ff.month;
   assign rsp_chan.year_out      = rsp_time_ff.year;
   assign rsp_chan.load_rejected = rsp_rejected_ff;

   assign rsp_fields_ok = (rsp_time_ff.minute <= MINUTE_MAX) &&
                          (rsp_time_ff.hour <= HOUR_MAX) &&
                          (rsp_time_ff.month <= MONTH_MAX) &&
                          (rsp_time_ff.year <= YEAR_MAX);
   assign step_fire     = req_fire && (req_chan.func < FUNC_LOAD_MINUTE);

   // Every accepted request must show up as a response in the next cycle.
   `CDTS_ASSERT_NEXT(a_fire_gives_rsp, clock, reset, req_fire, rsp_valid_ff, "request lost")

   // The minute, hour, month and year fields must never exceed their calendar maximums.
   `CDTS_ASSERT_SAME(a_rsp_in_range, clock, reset, rsp_valid_ff, rsp_fields_ok, "out of range")

   // Only load operations can be rejected.
   `CDTS_ASSERT_NEXT(a_step_not_rejected, clock, reset, step_fire, !rsp_rejected_ff, "bad reject")

endmodule

`default_nettype wire
